FILE: src/weighted_healthy_pick_top_defines.svh
// Assertion macros shared by the weighted host picker RTL.
`ifndef WEIGHTED_HEALTHY_PICK_TOP_DEFINES_SVH
`define WEIGHTED_HEALTHY_PICK_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define WHP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("weighted_healthy_pick: assertion failed");
`define WHP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("weighted_healthy_pick: assertion failed");
`else
`define WHP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define WHP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: src/whp_pkg.sv
// Types and constants of the weighted host picker.
`default_nettype none

package whp_pkg;

  localparam int HEALTH_BITS = 16;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_PICK  = 1'b1;

  // Register word index decoded from the configuration address.
  localparam logic REG_HOST_COUNT = 1'b0;
  localparam logic [4:0] HOST_COUNT_RST = 5'd16;

  typedef struct packed {
    logic        action;
    logic [3:0]  host_slot;
    logic [15:0] weight_value;
    logic [31:0] seed;
    logic [15:0] health_mask;
  } in_word_t;

  typedef struct packed {
    logic       found;
    logic [3:0] chosen_host;
  } out_word_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SUM  = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_SCAN = 5'b01000,
    ST_RESP = 5'b10000
  } whp_state_t;

endpackage

`default_nettype wire

FILE: src/whp_table.sv
// Weight memory: one write and one registered read port, per-entry valid bits.
`default_nettype none

module whp_table #(
  parameter int DEPTH  = 16,
  parameter int DATA_W = 16,
  parameter int AW     = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [AW-1:0]     rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  vld_r;
  logic [DATA_W-1:0] rd_data_r;
  logic              rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // An entry never written reads as zero, the reset weight.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

`default_nettype wire

FILE: src/whp_scale.sv
// Target scaling unit: (seed * sum) >> 32 with one shared 32x32 multiplier.
`default_nettype none

module whp_scale #(
  parameter int SUM_W = 20
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [31:0]      seed,
  input  wire logic [SUM_W-1:0] sum,
  output logic                  done,
  output logic      [SUM_W-1:0] target
);

  logic [63:0]      sum64;
  logic [31:0]      mul_b;
  logic [63:0]      prod_w;
  logic [63:0]      prod_r;
  logic [31:0]      plo_r;
  logic [2:0]       ph_r;
  logic [SUM_W-1:0] target_r;

  assign sum64 = 64'(sum);
  // The low half of the sum goes first, the high half on the second step.
  assign mul_b  = ph_r[0] ? sum64[63:32] : sum64[31:0];
  assign prod_w = seed * mul_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= 3'b000;
    end else if (start) begin
      ph_r <= 3'b001;
    end else begin
      ph_r <= {ph_r[1:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod_r <= prod_w;
    end else if (ph_r[0]) begin
      plo_r  <= prod_r[63:32];
      prod_r <= prod_w;
    end else if (ph_r[1]) begin
      target_r <= SUM_W'(prod_r + 64'(plo_r));
    end
  end

  assign done   = ph_r[2];
  assign target = target_r;

endmodule

`default_nettype wire

FILE: src/weighted_healthy_pick_top.sv
// Top level of the weighted healthy-host picker.
`default_nettype none
`include "weighted_healthy_pick_top_defines.svh"

// The block holds one weight per host in a single-port-read memory. A write
// word stores a weight and answers found = 0. A pick word works on n =
// min(host_count, MAX_HOSTS, 16) entries: one pass over the weight memory
// adds up the healthy weights, the shared 32x32 multiplier scales the seed,
// and a second pass walks the running sum until it passes the target,
// stopping at the chosen host; a zero sum answers found = 0 without scaling.
// Both passes read one entry per cycle through the memory's one read port.
// One word is worked on at a time; the next word is accepted while the
// previous result still waits in the output register.
module weighted_healthy_pick_top #(
  parameter int MAX_HOSTS   = 16,
  parameter int WEIGHT_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire whp_pkg::in_word_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output whp_pkg::out_word_t     out_data,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [2:0]        cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output logic      [31:0]       cfg_prdata,
  output logic                   cfg_pready
);

  import whp_pkg::*;

  localparam int AW       = (MAX_HOSTS > 1) ? $clog2(MAX_HOSTS) : 1;
  localparam int SCAN_MAX = (MAX_HOSTS < HEALTH_BITS) ? MAX_HOSTS : HEALTH_BITS;
  localparam int CNT_W    = $clog2(SCAN_MAX + 1);
  localparam int SUM_W    = WEIGHT_BITS + 4;

  whp_state_t state_r, state_nxt;

  logic [4:0]             host_count_r;
  logic [CNT_W-1:0]       n_r, n_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   pend_r, pend_nxt;
  logic                   hlth_pend_r;
  logic [3:0]             idx_pend_r;
  logic [31:0]            seed_r;
  logic [HEALTH_BITS-1:0] mask_r;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [SUM_W-1:0]       run_r, run_nxt;
  logic [SUM_W-1:0]       target_r;
  out_word_t              res_r, res_nxt;
  logic                   out_valid_r;
  out_word_t              out_data_r;

  logic                   in_acc;
  logic                   cfg_wr;
  logic                   tbl_wr_en;
  logic                   rd_en;
  logic [WEIGHT_BITS-1:0] rd_data;
  logic [SUM_W-1:0]       w_eff;
  logic                   pass_end;
  logic                   scale_start;
  logic                   scale_done;
  logic [SUM_W-1:0]       scale_target;
  logic                   out_free;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_HOST_COUNT) ? 32'(host_count_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      host_count_r <= HOST_COUNT_RST;
    end else if (cfg_wr && cfg_paddr[2] == REG_HOST_COUNT) begin
      host_count_r <= cfg_pwdata[4:0];
    end
  end

  // A slot beyond the table drops the weight.
  assign tbl_wr_en = in_acc && (in_data.action == ACT_WRITE) &&
                     (32'(in_data.host_slot) < MAX_HOSTS);
  assign rd_en     = ((state_r == ST_SUM) || (state_r == ST_SCAN)) && (cnt_r < n_r);

  whp_table #(
    .DEPTH  (MAX_HOSTS),
    .DATA_W (WEIGHT_BITS),
    .AW     (AW)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (tbl_wr_en),
    .wr_addr (AW'(in_data.host_slot)),
    .wr_data (WEIGHT_BITS'(in_data.weight_value)),
    .rd_en   (rd_en),
    .rd_addr (AW'(cnt_r)),
    .rd_data (rd_data)
  );

  whp_scale #(
    .SUM_W (SUM_W)
  ) u_scale (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (scale_start),
    .seed   (seed_r),
    .sum    (sum_r),
    .done   (scale_done),
    .target (scale_target)
  );

  assign w_eff    = hlth_pend_r ? SUM_W'(rd_data) : '0;
  assign pass_end = (cnt_r == n_r) && !pend_r;

  always_comb begin
    state_nxt   = state_r;
    n_nxt       = n_r;
    cnt_nxt     = cnt_r;
    pend_nxt    = rd_en;
    sum_nxt     = sum_r;
    run_nxt     = run_r;
    res_nxt     = res_r;
    scale_start = 1'b0;
    if (rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          res_nxt  = '0;
          cnt_nxt  = '0;
          pend_nxt = 1'b0;
          sum_nxt  = '0;
          if (host_count_r > 5'(SCAN_MAX)) begin
            n_nxt = CNT_W'(SCAN_MAX);
          end else begin
            n_nxt = CNT_W'(host_count_r);
          end
          if (in_data.action == ACT_PICK) begin
            state_nxt = ST_SUM;
          end else begin
            state_nxt = ST_RESP;
          end
        end
      end
      ST_SUM: begin
        if (pend_r) begin
          sum_nxt = sum_r + w_eff;
        end
        if (pass_end) begin
          if (sum_r == '0) begin
            state_nxt = ST_RESP;
          end else begin
            scale_start = 1'b1;
            state_nxt   = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        cnt_nxt  = '0;
        pend_nxt = 1'b0;
        run_nxt  = '0;
        if (scale_done) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (pend_r) begin
          run_nxt = run_r + w_eff;
          if (target_r < run_nxt) begin
            res_nxt.found       = 1'b1;
            res_nxt.chosen_host = idx_pend_r;
            state_nxt           = ST_RESP;
          end
        end
        if (pass_end) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      if ((state_r == ST_RESP) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    cnt_r <= cnt_nxt;
    sum_r <= sum_nxt;
    run_r <= run_nxt;
    res_r <= res_nxt;
    if (in_acc) begin
      seed_r <= in_data.seed;
      mask_r <= in_data.health_mask;
    end
    if (rd_en) begin
      hlth_pend_r <= mask_r[4'(cnt_r)];
      idx_pend_r  <= 4'(cnt_r);
    end
    if (scale_done) begin
      target_r <= scale_target;
    end
    if ((state_r == ST_RESP) && out_free) begin
      out_data_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `WHP_ASSERT_IMP(a_scan_bound, clk, rst_n, state_r == ST_SCAN, cnt_r <= n_r)
  `WHP_ASSERT_IMP(a_mul_nonzero, clk, rst_n, state_r == ST_MUL, sum_r != '0)
  `WHP_ASSERT_IMP(a_target_below_sum, clk, rst_n, state_r == ST_SCAN, target_r < sum_r)
  `WHP_ASSERT_NEXT(a_write_not_found, clk, rst_n, in_acc && in_data.action == ACT_WRITE, state_r == ST_RESP && res_r == '0)

endmodule

`default_nettype wire
